// ===== rtl/crse_pkg.sv =====
package crse_pkg;

   localparam int MAX_POINTS  = 16;
   localparam int PT_IDX_W    = $clog2(MAX_POINTS);
   localparam int CNT_W       = 5;
   localparam int CRD_W       = 24;
   localparam int T_FRAC_BITS = 16;
   localparam int SEG_W       = 4;
   localparam int T_W         = SEG_W + T_FRAC_BITS;
   localparam int TAPS        = 4;
   localparam int WGT_W       = 22;
   localparam int PROD_W      = WGT_W + CRD_W;
   localparam int SUM_W       = PROD_W + 3;
   localparam int SHR_W       = SUM_W - (T_FRAC_BITS + 1);

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_EVAL  = 1'b1;

   localparam logic CSR_LOOP_MODE   = 1'b0;
   localparam logic CSR_POINT_COUNT = 1'b1;

   typedef logic signed [CRD_W-1:0] crd_type;
   typedef logic signed [WGT_W-1:0] wgt_type;

   typedef struct packed {
      crd_type x;
      crd_type y;
   } point_type;

   typedef struct packed {
      logic                req_type;
      logic [PT_IDX_W-1:0] point_index;
      crd_type             point_x;
      crd_type             point_y;
      logic [T_W-1:0]      param_t;
   } req_payload_type;

   typedef struct packed {
      crd_type pos_x;
      crd_type pos_y;
      crd_type grad_x;
      crd_type grad_y;
      logic    status;
   } rsp_payload_type;

   typedef struct packed {
      logic valid;
      logic bad;
   } pipe_ctl_type;

endpackage

// ===== rtl/crse_point_mem.sv =====
module crse_point_mem (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [crse_pkg::PT_IDX_W-1:0] wr_addr,
   input  crse_pkg::point_type          wr_data,
   input  logic [crse_pkg::PT_IDX_W-1:0] rd_addr_a,
   input  logic [crse_pkg::PT_IDX_W-1:0] rd_addr_b,
   output crse_pkg::point_type          rd_data_a_ff,
   output crse_pkg::point_type          rd_data_b_ff
);
   import crse_pkg::*;

   point_type mem_ff [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

endmodule

// ===== rtl/crse_weights.sv =====
module crse_weights (
   input  logic                            clock,
   input  logic [crse_pkg::T_FRAC_BITS-1:0] frac,
   output crse_pkg::wgt_type               pos_wgt_ff [crse_pkg::TAPS],
   output crse_pkg::wgt_type               tan_wgt_ff [crse_pkg::TAPS]
);
   import crse_pkg::*;

   localparam int PW = 2 * T_FRAC_BITS + 1;
   localparam logic [PW-1:0] HALF = PW'(2 ** (T_FRAC_BITS - 1));
   localparam wgt_type UNIT_W = wgt_type'(2 ** T_FRAC_BITS);

   logic [T_FRAC_BITS-1:0] f_a_ff, tt_a_ff;
   logic [T_FRAC_BITS-1:0] f_b_ff, tt_b_ff, ttt_b_ff;
   logic [PW-1:0]          sq, cube;
   wgt_type                f_s, tt_s, ttt_s;
   wgt_type                pos_wgt_in [TAPS];
   wgt_type                tan_wgt_in [TAPS];

   // round half up
   always_comb begin
      sq   = PW'(frac) * PW'(frac) + HALF;
      cube = PW'(tt_a_ff) * PW'(f_a_ff) + HALF;
   end

   assign f_s   = wgt_type'($signed({1'b0, f_b_ff}));
   assign tt_s  = wgt_type'($signed({1'b0, tt_b_ff}));
   assign ttt_s = wgt_type'($signed({1'b0, ttt_b_ff}));

   always_comb begin
      pos_wgt_in[0] = -ttt_s + (tt_s <<< 1) - f_s;
      pos_wgt_in[1] = (ttt_s <<< 1) + ttt_s - (tt_s <<< 2) - tt_s + (UNIT_W <<< 1);
      pos_wgt_in[2] = -(ttt_s <<< 1) - ttt_s + (tt_s <<< 2) + f_s;
      pos_wgt_in[3] = ttt_s - tt_s;
      tan_wgt_in[0] = -(tt_s <<< 1) - tt_s + (f_s <<< 2) - UNIT_W;
      tan_wgt_in[1] = (tt_s <<< 3) + tt_s - (f_s <<< 3) - (f_s <<< 1);
      tan_wgt_in[2] = -(tt_s <<< 3) - tt_s + (f_s <<< 3) + UNIT_W;
      tan_wgt_in[3] = (tt_s <<< 1) + tt_s - (f_s <<< 1);
   end

   always_ff @(posedge clock) begin
      f_a_ff     <= frac;
      tt_a_ff    <= sq[2*T_FRAC_BITS-1:T_FRAC_BITS];
      f_b_ff     <= f_a_ff;
      tt_b_ff    <= tt_a_ff;
      ttt_b_ff   <= cube[2*T_FRAC_BITS-1:T_FRAC_BITS];
      pos_wgt_ff <= pos_wgt_in;
      tan_wgt_ff <= tan_wgt_in;
   end

endmodule

// ===== rtl/crse_mac.sv =====
module crse_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  crse_pkg::pipe_ctl_type    ctl,
   input  crse_pkg::wgt_type         pos_wgt [crse_pkg::TAPS],
   input  crse_pkg::wgt_type         tan_wgt [crse_pkg::TAPS],
   input  crse_pkg::point_type       pts [crse_pkg::TAPS],
   output logic                      rsp_valid_ff,
   output crse_pkg::rsp_payload_type rsp_data_ff
);
   import crse_pkg::*;

   localparam int OUTS = 4;
   localparam logic signed [SUM_W-1:0] ROUND  = SUM_W'(2 ** T_FRAC_BITS);
   localparam logic signed [SHR_W-1:0] SAT_HI = SHR_W'(2 ** (CRD_W - 1) - 1);
   localparam logic signed [SHR_W-1:0] SAT_LO = ~SAT_HI;

   logic signed [PROD_W-1:0] prod_in [OUTS][TAPS];
   logic signed [PROD_W-1:0] prod_ff [OUTS][TAPS];
   logic signed [SUM_W-1:0]  sum_in  [OUTS];
   logic signed [SUM_W-1:0]  sum_ff  [OUTS];
   crd_type                  res     [OUTS];
   pipe_ctl_type             ctl_p_ff, ctl_s_ff;
   rsp_payload_type          rsp_data_in;

   function automatic crd_type saturate(input logic signed [SHR_W-1:0] v);
      crd_type r;
      if (v > SAT_HI) begin
         r = SAT_HI[CRD_W-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[CRD_W-1:0];
      end else begin
         r = v[CRD_W-1:0];
      end
      return r;
   endfunction

   always_comb begin
      for (int k = 0; k < TAPS; k++) begin
         prod_in[0][k] = PROD_W'(pos_wgt[k]) * PROD_W'(pts[k].x);
         prod_in[1][k] = PROD_W'(pos_wgt[k]) * PROD_W'(pts[k].y);
         prod_in[2][k] = PROD_W'(tan_wgt[k]) * PROD_W'(pts[k].x);
         prod_in[3][k] = PROD_W'(tan_wgt[k]) * PROD_W'(pts[k].y);
      end
      for (int o = 0; o < OUTS; o++) begin
         sum_in[o] = SUM_W'(prod_ff[o][0]) + SUM_W'(prod_ff[o][1])
                   + SUM_W'(prod_ff[o][2]) + SUM_W'(prod_ff[o][3]) + ROUND;
         res[o] = saturate($signed(sum_ff[o][SUM_W-1:T_FRAC_BITS+1]));
      end
   end

   always_comb begin
      if (ctl_s_ff.bad) begin
         rsp_data_in = '0;
         rsp_data_in.status = 1'b1;
      end else begin
         rsp_data_in.pos_x  = res[0];
         rsp_data_in.pos_y  = res[1];
         rsp_data_in.grad_x = res[2];
         rsp_data_in.grad_y = res[3];
         rsp_data_in.status = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff     <= '0;
         ctl_s_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_p_ff     <= ctl;
         ctl_s_ff     <= ctl_p_ff;
         rsp_valid_ff <= ctl_s_ff.valid;
      end
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/catmull_rom_spline_eval.sv =====
// Catmull-Rom spline evaluator. A write item (req_type 0) stores one control
// point and gives no result; an evaluate item (req_type 1) gives position and
// tangent at param_t. busy is always low: one item is taken every cycle, and a
// point written in one cycle is seen by an evaluate taken in the next. A result
// is strobed on rsp_valid for one cycle, after the registered point read, the
// two rounding multiplies for t^2 and t^3, the weight stage, the coordinate
// multiplies, the tap sum and the saturating output register. Results come in
// request order and cannot be held off.
module catmull_rom_spline_eval (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  crse_pkg::req_payload_type         req_data,
   output logic                              rsp_valid,
   output crse_pkg::rsp_payload_type         rsp_data,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [crse_pkg::CNT_W-1:0]        csr_wdata
);
   import crse_pkg::*;

   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(4);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   logic                   loop_mode_ff;
   logic [CNT_W-1:0]       point_count_ff;
   logic                   accept, wr_en, bad_in;
   logic [CNT_W-1:0]       n, seg, nx2, nx3, sel2;
   logic [CNT_W-1:0]       idx [TAPS];
   logic [T_FRAC_BITS-1:0] f_s1_ff;
   pipe_ctl_type           ctl_in, ctl_s1_ff, ctl_s2_ff, ctl_s3_ff, ctl_s4_ff;
   point_type              wr_point;
   point_type              pts_s1 [TAPS];
   point_type              pts_s2_ff [TAPS];
   point_type              pts_s3_ff [TAPS];
   point_type              pts_s4_ff [TAPS];
   wgt_type                pos_wgt [TAPS];
   wgt_type                tan_wgt [TAPS];

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign wr_en  = accept && (req_data.req_type == REQ_WRITE);
   assign wr_point.x = req_data.point_x;
   assign wr_point.y = req_data.point_y;

   always_comb begin
      if (point_count_ff < CNT_MIN) begin
         n = CNT_MIN;
      end else if (point_count_ff > CNT_MAX) begin
         n = CNT_MAX;
      end else begin
         n = point_count_ff;
      end
      seg  = CNT_W'(req_data.param_t[T_W-1:T_FRAC_BITS]);
      nx2  = seg + CNT_W'(1);
      sel2 = (nx2 < n) ? nx2 : nx2 - n;
      nx3  = sel2 + CNT_W'(1);
      if (loop_mode_ff) begin
         bad_in = seg >= n;
         idx[0] = (seg == '0) ? n - CNT_W'(1) : seg - CNT_W'(1);
         idx[1] = seg;
         idx[2] = sel2;
         idx[3] = (nx3 < n) ? nx3 : nx3 - n;
      end else begin
         bad_in = (seg + CNT_W'(3)) >= n;
         idx[0] = seg;
         idx[1] = seg + CNT_W'(1);
         idx[2] = seg + CNT_W'(2);
         idx[3] = seg + CNT_W'(3);
      end
      ctl_in.valid = accept && (req_data.req_type == REQ_EVAL);
      ctl_in.bad   = bad_in;
   end

   crse_point_mem u_mem_lo (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (req_data.point_index),
      .wr_data      (wr_point),
      .rd_addr_a    (idx[0][PT_IDX_W-1:0]),
      .rd_addr_b    (idx[1][PT_IDX_W-1:0]),
      .rd_data_a_ff (pts_s1[0]),
      .rd_data_b_ff (pts_s1[1])
   );

   crse_point_mem u_mem_hi (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (req_data.point_index),
      .wr_data      (wr_point),
      .rd_addr_a    (idx[2][PT_IDX_W-1:0]),
      .rd_addr_b    (idx[3][PT_IDX_W-1:0]),
      .rd_data_a_ff (pts_s1[2]),
      .rd_data_b_ff (pts_s1[3])
   );

   crse_weights u_weights (
      .clock      (clock),
      .frac       (f_s1_ff),
      .pos_wgt_ff (pos_wgt),
      .tan_wgt_ff (tan_wgt)
   );

   crse_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl_s4_ff),
      .pos_wgt      (pos_wgt),
      .tan_wgt      (tan_wgt),
      .pts          (pts_s4_ff),
      .rsp_valid_ff (rsp_valid),
      .rsp_data_ff  (rsp_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_mode_ff   <= 1'b1;
         point_count_ff <= CNT_MAX;
         ctl_s1_ff      <= '0;
         ctl_s2_ff      <= '0;
         ctl_s3_ff      <= '0;
         ctl_s4_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOOP_MODE:   loop_mode_ff   <= csr_wdata[0];
               CSR_POINT_COUNT: point_count_ff <= csr_wdata;
               default:         ;
            endcase
         end
         ctl_s1_ff <= ctl_in;
         ctl_s2_ff <= ctl_s1_ff;
         ctl_s3_ff <= ctl_s2_ff;
         ctl_s4_ff <= ctl_s3_ff;
      end
      f_s1_ff   <= req_data.param_t[T_FRAC_BITS-1:0];
      pts_s2_ff <= pts_s1;
      pts_s3_ff <= pts_s2_ff;
      pts_s4_ff <= pts_s3_ff;
   end

endmodule
